/* src/sha_pkg.sv */
// sha-256 stream hasher package: round constants, initial hash values, fsm state type
// no dependencies
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } t_state;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] f_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    localparam logic [31:0] RC [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] f_ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* src/sha_if.sv */
// valid/ready channel interfaces for the sha-256 stream hasher
// no dependencies
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       message_end;
    modport source (output valid, data_byte, has_byte, message_end, input ready);
    modport sink (input valid, data_byte, has_byte, message_end, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* src/sha256_stream_hasher_top.sv */
// sha-256 stream hasher top level: byte buffer memory, control fsm, chaining words
// depends on sha_pkg, sha_if, sha_round
// a byte that fills no block is written to the buffer; a full block brings
// buffer reads and schedule load, 64 rounds and one fold, and no bytes are
// taken meanwhile; an end marker adds padding writes, one or two blocks, then
// 8 digest words; throughput is set by the byte-wide block buffer writes and the
// one-round-per-cycle compression
// reset: synchronous active-low; chaining words, fill and length return to start
module sha256_stream_hasher_top
    import sha_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    sha_in_if.sink    s_in,
    sha_out_if.source m_out
);
    // block buffer as 16 words of 32 bits, byte-enable writes, registered read
    logic [31:0] r_mem [16];
    logic [31:0] r_rd;

    t_state      r_state, n_state;
    logic [5:0]  r_fill;      // buffered bytes 0..63
    logic [63:0] r_bits;      // message length in bits
    logic [31:0] r_chain [8];
    logic [6:0]  r_cnt;       // round / load / emit counter
    logic        r_fin;       // digest pending after current block
    logic        r_len;       // this block carries the length field
    logic        r_pad_done;  // 0x80 marker already written for this message
    logic [31:0] vars [8];

    logic       mem_we;
    logic [5:0] mem_wa;
    logic [7:0] mem_wd;
    logic [3:0] mem_ra;

    logic init, ld, step;

    // byte write, big-endian lane within the word
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa[5:2]][8 * (3 - mem_wa[1:0]) +: 8] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    // word fed to the schedule: length field overrides the last two words
    logic [31:0] ld_word;
    always_comb begin
        ld_word = r_rd;
        if (r_len && r_cnt == 7'd15) ld_word = r_bits[63:32];
        if (r_len && r_cnt == 7'd16) ld_word = r_bits[31:0];
    end

    sha_round u_round (
        .i_clk   (i_clk),
        .i_init  (init),
        .i_chain (r_chain),
        .i_load  (ld),
        .i_word  (ld_word),
        .i_step  (step),
        .i_round (r_cnt[5:0]),
        .o_vars  (vars)
    );

    wire acc = s_in.valid && s_in.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    if (s_in.has_byte && r_fill == 6'd63) n_state = ST_LOAD;
                    else if (s_in.message_end) n_state = ST_PAD;
                end
            end
            ST_LOAD:  if (r_cnt == 7'd16) n_state = ST_ROUND;
            ST_ROUND: if (r_cnt == 7'd63) n_state = ST_FOLD;
            ST_FOLD:  begin
                if (r_len) n_state = ST_EMIT;
                else if (r_fin) n_state = ST_PAD;
                else n_state = ST_IDLE;
            end
            // pad writes 0x80 then zeros up to byte 55 (length fits) or to the block end
            ST_PAD: begin
                if (r_fill == 6'd55 || r_fill == 6'd63) n_state = ST_LOAD;
            end
            ST_EMIT: if (m_out.ready && r_cnt == 7'd7) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_in.ready = (r_state == ST_IDLE);
        mem_we = 1'b0;
        mem_wa = r_fill;
        mem_wd = 8'h00;
        mem_ra = r_cnt[3:0];
        init = 1'b0;
        ld = 1'b0;
        step = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                mem_we = acc && s_in.has_byte;
                mem_wd = s_in.data_byte;
                mem_ra = 4'd0;
            end
            ST_LOAD: begin
                // r_cnt 0 issues read 0; each word arrives in the following cycle from the registered read
                mem_ra = r_cnt[3:0];
                init = (r_cnt == 7'd0);
                ld = (r_cnt != 7'd0);
            end
            ST_ROUND: step = 1'b1;
            ST_PAD: begin
                mem_we = 1'b1;
                mem_wd = r_pad_done ? 8'h00 : PAD_BYTE;
            end
            default: ;
        endcase
        m_out.valid = (r_state == ST_EMIT);
        m_out.digest_word = r_chain[r_cnt[2:0]];
        m_out.word_index = r_cnt[2:0];
        m_out.last_word = (r_cnt[2:0] == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill <= '0;
            r_bits <= '0;
            r_cnt <= '0;
            r_fin <= 1'b0;
            r_len <= 1'b0;
            r_pad_done <= 1'b0;
            for (int k = 0; k < 8; k++) r_chain[k] <= f_iv(3'(k));
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (acc) begin
                        r_fin <= s_in.message_end;
                        r_len <= 1'b0;
                        r_pad_done <= 1'b0;
                        if (s_in.has_byte) begin
                            r_fill <= r_fill + 6'd1;
                            r_bits <= r_bits + 64'd8;
                        end
                    end
                end
                ST_LOAD: begin
                    r_cnt <= (r_cnt == 7'd16) ? 7'd0 : r_cnt + 7'd1;
                end
                ST_ROUND: r_cnt <= r_cnt + 7'd1;
                ST_FOLD: begin
                    r_cnt <= '0;
                    for (int k = 0; k < 8; k++) r_chain[k] <= r_chain[k] + vars[k];
                end
                ST_PAD: begin
                    r_cnt <= r_cnt + 7'd1;
                    r_fill <= r_fill + 6'd1;
                    r_pad_done <= 1'b1;
                    if (r_fill == 6'd55 || r_fill == 6'd63) begin
                        // stopping at byte 55 leaves room for the length
                        r_len <= (r_fill == 6'd55);
                        r_cnt <= '0;
                        r_fill <= '0;
                    end
                end
                ST_EMIT: begin
                    if (m_out.ready) begin
                        r_cnt <= r_cnt + 7'd1;
                        if (r_cnt == 7'd7) begin
                            r_cnt <= '0;
                            r_fin <= 1'b0;
                            r_len <= 1'b0;
                            r_bits <= '0;
                            r_fill <= '0;
                            for (int k = 0; k < 8; k++) r_chain[k] <= f_iv(3'(k));
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* src/sha_round.sv */
// sha-256 round datapath: working variables and 16-word rolling message schedule
// depends on sha_pkg
module sha_round
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_init,
    input  logic [31:0] i_chain [8],
    input  logic        i_load,
    input  logic [31:0] i_word,
    input  logic        i_step,
    input  logic [5:0]  i_round,
    output logic [31:0] o_vars [8]
);
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] wi, s0, s1, t1, t2, b0, b1, ch, mj;

    always_comb begin
        s0 = f_ror(r_w[1], 7) ^ f_ror(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = f_ror(r_w[14], 17) ^ f_ror(r_w[14], 19) ^ (r_w[14] >> 10);
        // first 16 rounds use the loaded words, then the expanded schedule
        wi = (i_round < 6'd16) ? r_w[0] : (r_w[0] + s0 + r_w[9] + s1);
        b1 = f_ror(r_v[4], 6) ^ f_ror(r_v[4], 11) ^ f_ror(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + b1 + ch + RC[i_round] + wi;
        b0 = f_ror(r_v[0], 2) ^ f_ror(r_v[0], 13) ^ f_ror(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = b0 + mj;
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_v <= i_chain;
        end else if (i_step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_load || i_step) begin
            for (int k = 0; k < 15; k++) r_w[k] <= r_w[k + 1];
            r_w[15] <= i_load ? i_word : wi;
        end
    end

    assign o_vars = r_v;
endmodule
